FILE: rtl/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared constants and types for the modular inverse block.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam logic [63:0] ResetModulus = 64'd1000000007;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCheck  = 5'b00010,
    StDiv    = 5'b00100,
    StReduce = 5'b01000,
    StEmit   = 5'b10000
  } state_e;

endpackage

FILE: rtl/mi_if.sv
// ----------------------------------------------------------------------------
// mi_if
// Valid/ready channels of the modular inverse block.
// ----------------------------------------------------------------------------
interface mi_in_if #(
  parameter int unsigned DW = mi_pkg::DataWidth
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mi_out_if #(
  parameter int unsigned DW = mi_pkg::DataWidth
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] inverse;
  logic          has_inverse;
  logic [DW-1:0] common_divisor;

  modport source (output valid, output inverse, output has_inverse,
                  output common_divisor, input ready);
  modport sink   (input valid, input inverse, input has_inverse,
                  input common_divisor, output ready);
endinterface

interface mi_cfg_if #(
  parameter int unsigned DW = mi_pkg::DataWidth
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

FILE: rtl/mi_divstep.sv
// ----------------------------------------------------------------------------
// mi_divstep
// Shared shift-subtract unit: one quotient bit per cycle, with the quotient
// times the current coefficient accumulated alongside.
// ----------------------------------------------------------------------------
module mi_divstep #(
  parameter int unsigned DW = mi_pkg::DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mi_pkg::div_ctl_t ctl_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [DW-1:0]    divisor_i,
  input  logic [DW:0]      mult_i,
  output mi_pkg::div_sts_t sts_o,
  output logic [DW-1:0]    rem_o,
  output logic [DW:0]      acc_o
);

  localparam int unsigned   CntW    = $clog2(DW);
  localparam logic [CntW-1:0] CntLast = CntW'(DW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   dvd_q;
  logic [DW-1:0]   rem_q;
  logic [DW:0]     acc_q;

  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic        ge;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntLast;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      acc_q <= {acc_q[DW-1:0], 1'b0} + (ge ? mult_i : '0);
    end
  end

  assign sts_o.done = done_q;
  assign rem_o      = rem_q;
  assign acc_o      = acc_q;

endmodule

FILE: rtl/mi_ctrl.sv
// ----------------------------------------------------------------------------
// mi_ctrl
// Euclid sequencer: holds remainders and coefficient magnitudes, drives the
// shared divide unit and reduces the final coefficient.
// ----------------------------------------------------------------------------
module mi_ctrl #(
  parameter int unsigned DW = mi_pkg::DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [DW-1:0]    in_value_i,
  output logic             in_ready_o,
  input  logic [DW-1:0]    modulus_i,
  input  logic             out_full_i,
  output logic             res_valid_o,
  output logic [DW-1:0]    res_inverse_o,
  output logic             res_has_o,
  output logic [DW-1:0]    res_gcd_o,
  output mi_pkg::div_ctl_t div_ctl_o,
  input  mi_pkg::div_sts_t div_sts_i,
  output logic [DW-1:0]    div_dividend_o,
  output logic [DW-1:0]    div_divisor_o,
  output logic [DW:0]      div_mult_o,
  input  logic [DW-1:0]    div_rem_i,
  input  logic [DW:0]      div_acc_i
);

  mi_pkg::state_e state_q, state_d;

  logic [DW-1:0] rold_q;
  logic [DW-1:0] rcur_q;
  logic [DW:0]   mold_q;
  logic [DW:0]   mcur_q;
  logic          neg_q;
  logic [DW-1:0] red_q;

  logic          accept;
  logic          ok;
  logic [DW:0]   mod_ext;
  logic [DW:0]   red_sub;

  assign in_ready_o = (state_q == mi_pkg::StIdle) && !out_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mod_ext    = {1'b0, modulus_i};
  assign red_sub    = mold_q - mod_ext;
  assign ok         = (modulus_i != '0) && (rold_q == DW'(1));

  assign div_ctl_o.start = (state_q == mi_pkg::StCheck) && (rcur_q != '0);
  assign div_dividend_o  = rold_q;
  assign div_divisor_o   = rcur_q;
  assign div_mult_o      = mcur_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mi_pkg::StIdle:   if (accept) state_d = mi_pkg::StCheck;
      mi_pkg::StCheck:  state_d = (rcur_q != '0) ? mi_pkg::StDiv : mi_pkg::StReduce;
      mi_pkg::StDiv:    if (div_sts_i.done) state_d = mi_pkg::StCheck;
      mi_pkg::StReduce: state_d = mi_pkg::StEmit;
      mi_pkg::StEmit:   state_d = mi_pkg::StIdle;
      default:          state_d = mi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mi_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mi_pkg::StIdle: begin
        if (accept) begin
          rold_q <= in_value_i;
          rcur_q <= modulus_i;
          mold_q <= (DW+1)'(1);
          mcur_q <= '0;
          neg_q  <= 1'b0;
        end
      end
      mi_pkg::StDiv: begin
        if (div_sts_i.done) begin
          rold_q <= rcur_q;
          rcur_q <= div_rem_i;
          mold_q <= mcur_q;
          mcur_q <= mold_q + div_acc_i;
          neg_q  <= !neg_q;
        end
      end
      mi_pkg::StReduce: begin
        red_q <= (mold_q >= mod_ext) ? red_sub[DW-1:0] : mold_q[DW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o   = (state_q == mi_pkg::StEmit);
  assign res_has_o     = ok;
  assign res_gcd_o     = rold_q;
  assign res_inverse_o = !ok ? '0 :
                         (neg_q && red_q != '0) ? (modulus_i - red_q) : red_q;

endmodule

FILE: rtl/modular_inverse.sv
// Each step passes through a check state and then runs on the shared
//   shift-subtract unit, which retires one quotient bit per cycle.
// Throughput: one item at a time; the next is taken once the result has left.
// Reset: asynchronous, active low; modulus returns to 1000000007.
// ----------------------------------------------------------------------------
// modular_inverse
// Modular inverse by the extended Euclidean algorithm on one shared unit.
// ----------------------------------------------------------------------------
module modular_inverse #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DataWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi_cfg_if.sink    cfg_i,
  mi_in_if.sink     in_i,
  mi_out_if.source  out_o
);

  localparam logic [DATA_WIDTH-1:0] ResetMod = DATA_WIDTH'(mi_pkg::ResetModulus);

  logic [DATA_WIDTH-1:0] modulus_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_inverse_q;
  logic                  out_has_q;
  logic [DATA_WIDTH-1:0] out_gcd_q;

  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_inverse;
  logic                  res_has;
  logic [DATA_WIDTH-1:0] res_gcd;

  mi_pkg::div_ctl_t      div_ctl;
  mi_pkg::div_sts_t      div_sts;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic [DATA_WIDTH-1:0] div_divisor;
  logic [DATA_WIDTH:0]   div_mult;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH:0]   div_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ResetMod;
    end else if (cfg_i.valid) begin
      modulus_q <= cfg_i.modulus;
    end
  end

  mi_ctrl #(.DW(DATA_WIDTH)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_value_i     (in_i.value),
    .in_ready_o     (in_i.ready),
    .modulus_i      (modulus_q),
    .out_full_i     (out_valid_q),
    .res_valid_o    (res_valid),
    .res_inverse_o  (res_inverse),
    .res_has_o      (res_has),
    .res_gcd_o      (res_gcd),
    .div_ctl_o      (div_ctl),
    .div_sts_i      (div_sts),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_mult_o     (div_mult),
    .div_rem_i      (div_rem),
    .div_acc_i      (div_acc)
  );

  mi_divstep #(.DW(DATA_WIDTH)) u_divstep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .mult_i     (div_mult),
    .sts_o      (div_sts),
    .rem_o      (div_rem),
    .acc_o      (div_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_inverse_q <= res_inverse;
      out_has_q     <= res_has;
      out_gcd_q     <= res_gcd;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.inverse        = out_inverse_q;
  assign out_o.has_inverse    = out_has_q;
  assign out_o.common_divisor = out_gcd_q;

endmodule

FILE: rtl/mi_checker.sv
// ----------------------------------------------------------------------------
// mi_checker
// Port-level checks for the modular inverse block.
// ----------------------------------------------------------------------------
module mi_checker #(
  parameter int unsigned DW = mi_pkg::DataWidth
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [DW-1:0] out_inverse_i,
  input logic          out_has_i,
  input logic [DW-1:0] out_gcd_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_inverse_i) && $stable(out_has_i)
                                    && $stable(out_gcd_i))
    else $error("result item changed while stalled");

  a_has_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_has_i |-> out_gcd_i == DW'(1))
    else $error("inverse flagged with divisor other than one");

  a_no_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_has_i |-> out_inverse_i == '0)
    else $error("nonzero inverse without inverse flag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("next item taken while one is in progress");

endmodule

bind modular_inverse mi_checker #(.DW(DATA_WIDTH)) u_mi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_inverse_i (out_o.inverse),
  .out_has_i     (out_o.has_inverse),
  .out_gcd_i     (out_o.common_divisor)
);

FILE: verif/tb_modular_inverse.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_inverse
// Self-checking bench for the modular inverse block. Items go in with random
// gaps and results are taken with random stalls. Each result is checked
// against an extended Euclid predictor that runs on the modulus in force.
// The run covers the reset modulus, the extreme and degenerate moduli,
// back-pressure that fills the block, and random phases of values.
// ----------------------------------------------------------------------------
module tb_modular_inverse;

  localparam int unsigned DW          = mi_pkg::DataWidth;
  localparam int unsigned StallLimit  = 40000;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned DrainCycles = 2000;
  localparam int unsigned HoldOff     = 1500;

  typedef logic [DW-1:0] word_t;

  typedef struct packed {
    word_t inverse;
    logic  has_inverse;
    word_t common_divisor;
  } inv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mi_cfg_if cfg_ch ();
  mi_in_if  in_ch ();
  mi_out_if out_ch ();

  modular_inverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  word_t       modulus_now;
  inv_result_t pending_results [$];
  int unsigned error_count      = 0;
  int unsigned items_sent       = 0;
  int unsigned results_seen     = 0;
  int unsigned inverses_seen    = 0;
  int unsigned config_writes    = 0;
  int unsigned idle_cycles      = 0;
  int unsigned hold_off_request = 0;
  bit          steady_flow      = 1'b0;

  always #6 clk_i = ~clk_i;

  function automatic inv_result_t predict_inverse(input word_t a, input word_t n);
    longint unsigned rem_a, rem_b, rem_next, quo, mag_a, mag_b, mag_next, red;
    bit              odd;
    inv_result_t     res;
    rem_a = a;
    rem_b = n;
    mag_a = 1;
    mag_b = 0;
    odd   = 1'b0;
    while (rem_b != 0) begin
      quo      = rem_a / rem_b;
      rem_next = rem_a - quo * rem_b;
      mag_next = mag_a + quo * mag_b;
      rem_a    = rem_b;
      rem_b    = rem_next;
      mag_a    = mag_b;
      mag_b    = mag_next;
      odd      = ~odd;
    end
    res.common_divisor = word_t'(rem_a);
    res.has_inverse    = (n != 0) && (rem_a == 1);
    res.inverse        = '0;
    if (res.has_inverse) begin
      red = mag_a % n;
      res.inverse = (odd && red != 0) ? word_t'(n - red) : word_t'(red);
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 120);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 250);
  endfunction

  function automatic word_t pick_value(input word_t n);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom());
      4, 5:       return (n == 0) ? word_t'($urandom()) : word_t'($urandom_range(0, n - 1));
      6:          return word_t'(n * $urandom_range(1, 3));
      7: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return word_t'(1);
          2:       return n - 1;
          3:       return n;
          4:       return n + 1;
          default: return '1;
        endcase
      end
      8:          return word_t'((n >> $urandom_range(1, 8)) * $urandom_range(1, 5));
      default:    return word_t'($urandom() << $urandom_range(0, 31));
    endcase
  endfunction

  function automatic word_t pick_modulus(input int unsigned phase);
    case (phase % 12)
      0:       return mi_pkg::ResetModulus[DW-1:0];
      1:       return '1;
      2:       return word_t'($urandom());
      3:       return word_t'($urandom() | 1);
      4:       return word_t'(32'h8000_0000);
      5:       return word_t'($urandom_range(2, 255));
      6:       return word_t'($urandom_range(256, 65535));
      7:       return word_t'(360360);
      8:       return word_t'(1);
      9:       return word_t'($urandom_range(32'h1_0000, 32'h100_0000));
      10:      return '0;
      default: return word_t'(32'hFFFF_FFFB);
    endcase
  endfunction

  task automatic send_value(input word_t value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_results.push_back(predict_inverse(value, modulus_now));
    items_sent++;
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_modulus(input word_t modulus);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= modulus;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    modulus_now = modulus;
    config_writes++;
  endtask

  task automatic test_reset_modulus();
    send_value('0);
    send_value(word_t'(1));
    send_value(word_t'(2));
    send_value(word_t'(1000000006));
    send_value(word_t'(1000000007));
    send_value(word_t'(2000000014));
    send_value('1);
  endtask

  task automatic test_edge_moduli();
    write_modulus('1);
    send_value('0);
    send_value(word_t'(1));
    send_value(word_t'(2));
    send_value(word_t'(3));
    send_value(word_t'(32'hFFFF_FFFE));
    send_value('1);
    write_modulus(word_t'(1));
    send_value('0);
    send_value(word_t'(1));
    send_value('1);
    write_modulus('0);
    send_value('0);
    send_value(word_t'(1));
    send_value(word_t'(12345));
    send_value('1);
    write_modulus(word_t'(32'h8000_0000));
    send_value(word_t'(32'h8000_0000));
    send_value(word_t'(3));
    send_value(word_t'(6));
  endtask

  task automatic test_back_pressure();
    write_modulus(word_t'(1000003));
    steady_flow      = 1'b1;
    hold_off_request = HoldOff;
    repeat (8) send_value(pick_value(modulus_now));
    steady_flow = 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned phase;
    int unsigned count;
    int unsigned sent;
    phase = 0;
    sent  = 0;
    while (sent < RandomItems) begin
      write_modulus(pick_modulus(phase));
      count       = (modulus_now <= 1) ? $urandom_range(10, 25) : $urandom_range(80, 180);
      if (count > RandomItems - sent) count = RandomItems - sent;
      steady_flow = (phase % 5 == 4);
      repeat (count) send_value(pick_value(modulus_now));
      sent += count;
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk_i) begin : result_sink
    inv_result_t want;
    int unsigned stall_left;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: inverse=%0d has_inverse=%0b common_divisor=%0d",
               out_ch.inverse, out_ch.has_inverse, out_ch.common_divisor);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.has_inverse) inverses_seen++;
        if (out_ch.inverse !== want.inverse) begin
          $error("inverse: expected %0d, actual %0d", want.inverse, out_ch.inverse);
          error_count++;
        end
        if (out_ch.has_inverse !== want.has_inverse) begin
          $error("has_inverse: expected %0b, actual %0b", want.has_inverse,
                 out_ch.has_inverse);
          error_count++;
        end
        if (out_ch.common_divisor !== want.common_divisor) begin
          $error("common_divisor: expected %0d, actual %0d", want.common_divisor,
                 out_ch.common_divisor);
          error_count++;
        end
      end
    end
    if (hold_off_request != 0) begin
      stall_left       = hold_off_request;
      hold_off_request = 0;
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
      stall_left = pick_stall() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == StallLimit) begin
      $display("tb_modular_inverse: done, errors");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.modulus <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.value    <= '0;
    modulus_now = mi_pkg::ResetModulus[DW-1:0];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_modulus();
    test_edge_moduli();
    test_back_pressure();
    test_random_phases();

    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_modular_inverse: %0d items over %0d modulus settings, %0d results checked",
             items_sent, config_writes + 1, results_seen);
    $display("tb_modular_inverse: %0d results carried an inverse, %0d had none",
             inverses_seen, results_seen - inverses_seen);
    if (error_count == 0) begin
      $display("tb_modular_inverse: done, clean");
    end else begin
      $display("tb_modular_inverse: done, errors");
    end
    $finish;
  end

endmodule
